/* rtl/modbus_slave_register_engine_top_macros.svh */
// assertion helpers for the register engine
`ifndef MODBUS_SLAVE_REGISTER_ENGINE_TOP_MACROS_SVH
`define MODBUS_SLAVE_REGISTER_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps
package mse_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_REG_READ  = 31;
  localparam int MAX_BIT_READ  = 496;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int N_W   = $clog2(MAX_BIT_READ + 1);

  localparam logic [15:0] ON_VALUE   = 16'hFF00;
  localparam logic [15:0] BASE_COIL  = 16'd1;
  localparam logic [15:0] BASE_DISC  = 16'd10001;
  localparam logic [15:0] BASE_INREG = 16'd30001;
  localparam logic [15:0] BASE_HOLD  = 16'd40001;

  localparam logic [7:0] FC_RD_COIL    = 8'd1;
  localparam logic [7:0] FC_READ_DISC  = 8'd2;
  localparam logic [7:0] FC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FC_READ_INREG = 8'd4;
  localparam logic [7:0] FC_WR_COIL    = 8'd5;
  localparam logic [7:0] FC_WR_HOLD    = 8'd6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_PDU   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_BYTE = 3'd0,
    ST_ECHO = 3'd1,
    ST_DONE = 3'd2,
    ST_MISS = 3'd3,
    ST_IGN  = 3'd4,
    ST_BIG  = 3'd5,
    ST_FULL = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    K_ADD,
    K_LWR,
    K_LRD,
    K_WRE,
    K_BITS,
    K_REGS,
    K_IMM
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_LOOK,
    S_CMP,
    S_RES,
    S_LO,
    S_HFC,
    S_HCNT
  } state_e;

  typedef struct packed {
    kind_e          kind;
    status_e        status;
    logic [15:0]    addr;
    logic [15:0]    wval;
    logic [7:0]     fc;
    logic [N_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  reply_byte;
    logic [15:0] read_value;
    logic        last;
  } res_t;

  function automatic logic [15:0] region_base(input logic [1:0] region);
    logic [15:0] b;
    case (region)
      2'd0:    b = BASE_COIL;
      2'd1:    b = BASE_DISC;
      2'd2:    b = BASE_INREG;
      default: b = BASE_HOLD;
    endcase
    return b;
  endfunction

endpackage

/* rtl/mse_front.sv */
`timescale 1ns / 1ps
module mse_front (
  input  logic [1:0]    opcode_i,
  input  logic [1:0]    region_i,
  input  logic [15:0]   offset_i,
  input  logic [15:0]   local_value_i,
  input  logic [7:0]    function_code_i,
  input  logic [15:0]   first_field_i,
  input  logic [15:0]   second_field_i,
  output mse_pkg::cmd_t cmd_o
);
  import mse_pkg::*;

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = K_IMM;
    cmd_o.status = ST_IGN;
    cmd_o.addr   = region_base(region_i) + offset_i;
    cmd_o.wval   = local_value_i;
    cmd_o.fc     = function_code_i;
    cmd_o.cnt    = second_field_i[N_W-1:0];
    case (op_e'(opcode_i))
      OP_ADD: begin
        cmd_o.kind = K_ADD;
      end
      OP_WRITE: begin
        cmd_o.kind = K_LWR;
        if (!region_i[1]) begin
          cmd_o.wval = (local_value_i != 16'd0) ? ON_VALUE : 16'd0;
        end
      end
      OP_READ: begin
        cmd_o.kind = K_LRD;
      end
      default: begin
        cmd_o.wval = second_field_i;
        case (function_code_i)
          FC_WR_COIL: begin
            cmd_o.addr = first_field_i + BASE_COIL;
            if (second_field_i == ON_VALUE || second_field_i == 16'd0) begin
              cmd_o.kind = K_WRE;
            end else begin
              cmd_o.status = ST_ECHO;
            end
          end
          FC_WR_HOLD: begin
            cmd_o.addr = first_field_i + BASE_HOLD;
            cmd_o.kind = K_WRE;
          end
          FC_RD_COIL, FC_READ_DISC: begin
            cmd_o.addr = first_field_i +
              ((function_code_i == FC_RD_COIL) ? BASE_COIL : BASE_DISC);
            if (second_field_i > 16'(MAX_BIT_READ)) begin
              cmd_o.status = ST_BIG;
            end else begin
              cmd_o.kind = K_BITS;
            end
          end
          FC_READ_HOLD, FC_READ_INREG: begin
            cmd_o.addr = first_field_i +
              ((function_code_i == FC_READ_HOLD) ? BASE_HOLD : BASE_INREG);
            if (second_field_i > 16'(MAX_REG_READ)) begin
              cmd_o.status = ST_BIG;
            end else begin
              cmd_o.kind = K_REGS;
            end
          end
          default: begin
            cmd_o.status = ST_IGN;
          end
        endcase
      end
    endcase
  end

endmodule

/* rtl/mse_cmd_fifo.sv */
`timescale 1ns / 1ps
module mse_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mse_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mse_pkg::cmd_t data_o
);
  import mse_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/mse_back.sv */
`timescale 1ns / 1ps
module mse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  mse_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output mse_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import mse_pkg::*;

  logic [15:0] addr_mem [TABLE_ENTRIES];
  logic [15:0] val_mem  [TABLE_ENTRIES];

  state_e         state_q, state_d;
  cmd_t           cmd_q, cmd_d;
  logic [CNT_W-1:0] idx_q, idx_d, count_q, count_d;
  logic [N_W-1:0] elem_q, elem_d;
  logic [15:0]    cur_q, cur_d;
  logic [7:0]     byte_q, byte_d;
  logic [2:0]     bitpos_q, bitpos_d;
  logic           found_q, found_d;
  logic [15:0]    hit_q, hit_d;
  logic [15:0]    rd_addr_q, rd_val_q;
  logic           out_valid_q, out_valid_d;
  res_t           out_q, out_d;

  logic           out_free, lastel, bit_v, emit_bit, at_end, match;
  logic           rd_en, add_we, val_we;
  logic [7:0]     newbyte;
  logic [N_W:0]   nbytes;

  assign out_free = !out_valid_q || res_ready_i;
  assign lastel   = (elem_q + N_W'(1)) == cmd_q.cnt;
  assign bit_v    = found_q && (hit_q == ON_VALUE);
  assign newbyte  = byte_q | (8'(bit_v) << bitpos_q);
  assign emit_bit = (bitpos_q == 3'd7) || lastel;
  assign at_end   = idx_q == count_q;
  assign match    = rd_addr_q == cur_q;
  assign nbytes   = ({1'b0, cmd_q.cnt} + (N_W+1)'(7)) >> 3;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            K_ADD, K_IMM:   state_d = S_ONE;
            K_BITS, K_REGS: state_d = S_HFC;
            default:        state_d = S_LOOK;
          endcase
        end
      end
      S_ONE:  if (out_free) state_d = S_IDLE;
      S_LOOK: state_d = at_end ? S_RES : S_CMP;
      S_CMP:  state_d = match ? S_RES : S_LOOK;
      S_HFC:  if (out_free) state_d = S_HCNT;
      S_HCNT: if (out_free) state_d = (cmd_q.cnt == '0) ? S_IDLE : S_LOOK;
      S_RES: begin
        case (cmd_q.kind)
          K_BITS: begin
            if (!emit_bit || out_free) state_d = lastel ? S_IDLE : S_LOOK;
          end
          K_REGS:  if (out_free) state_d = S_LO;
          default: if (out_free) state_d = S_IDLE;
        endcase
      end
      S_LO:    if (out_free) state_d = lastel ? S_IDLE : S_LOOK;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    count_d     = count_q;
    elem_d      = elem_q;
    cur_d       = cur_q;
    byte_d      = byte_q;
    bitpos_d    = bitpos_q;
    found_d     = found_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    add_we      = 1'b0;
    val_we      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cur_d     = cmd_i.addr;
          idx_d     = '0;
          elem_d    = '0;
          bitpos_d  = '0;
          byte_d    = '0;
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: cmd_q.status, reply_byte: '0, read_value: '0, last: 1'b1};
          if (cmd_q.kind == K_ADD) begin
            if (count_q == CNT_W'(TABLE_ENTRIES)) begin
              out_d.status = ST_FULL;
            end else begin
              add_we       = 1'b1;
              count_d      = count_q + CNT_W'(1);
              out_d.status = ST_DONE;
            end
          end
        end
      end
      S_LOOK: begin
        if (at_end) begin
          found_d = 1'b0;
          hit_d   = '0;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_CMP: begin
        if (match) begin
          found_d = 1'b1;
          hit_d   = rd_val_q;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_HFC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: ST_BYTE, reply_byte: cmd_q.fc, read_value: '0,
                    last: cmd_q.cnt == '0};
        end
      end
      S_HCNT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: ST_BYTE, reply_byte: '0, read_value: '0,
                    last: cmd_q.cnt == '0};
          if (cmd_q.kind == K_BITS) begin
            out_d.reply_byte = nbytes[7:0];
          end else begin
            out_d.reply_byte = {cmd_q.cnt[6:0], 1'b0};
          end
        end
      end
      S_RES: begin
        case (cmd_q.kind)
          K_BITS: begin
            if (!emit_bit || out_free) begin
              byte_d = newbyte;
              if (emit_bit) begin
                out_valid_d = 1'b1;
                out_d = '{status: ST_BYTE, reply_byte: newbyte, read_value: '0,
                          last: lastel};
                byte_d = '0;
              end
              elem_d   = elem_q + N_W'(1);
              cur_d    = cur_q + 16'd1;
              idx_d    = '0;
              bitpos_d = bitpos_q + 3'd1;
            end
          end
          K_REGS: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = '{status: ST_BYTE, reply_byte: hit_q[15:8], read_value: '0,
                        last: 1'b0};
            end
          end
          K_LRD: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_d = '{status: found_q ? ST_DONE : ST_MISS, reply_byte: '0,
                        read_value: hit_q, last: 1'b1};
            end
          end
          default: begin
            if (out_free) begin
              val_we      = found_q;
              out_valid_d = 1'b1;
              out_d = '{status: ST_ECHO, reply_byte: '0, read_value: '0, last: 1'b1};
              if (cmd_q.kind == K_LWR) begin
                out_d.status = found_q ? ST_DONE : ST_MISS;
              end
            end
          end
        endcase
      end
      S_LO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: ST_BYTE, reply_byte: hit_q[7:0], read_value: '0,
                    last: lastel};
          elem_d = elem_q + N_W'(1);
          cur_d  = cur_q + 16'd1;
          idx_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    elem_q   <= elem_d;
    cur_q    <= cur_d;
    byte_q   <= byte_d;
    bitpos_q <= bitpos_d;
    found_q  <= found_d;
    hit_q    <= hit_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      addr_mem[count_q[IDX_W-1:0]] <= cmd_q.addr;
    end
    if (rd_en) begin
      rd_addr_q <= addr_mem[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      val_mem[count_q[IDX_W-1:0]] <= '0;
    end else if (val_we) begin
      val_mem[idx_q[IDX_W-1:0]] <= cmd_q.wval;
    end
    if (rd_en) begin
      rd_val_q <= val_mem[idx_q[IDX_W-1:0]];
    end
  end

endmodule

/* rtl/modbus_slave_register_engine_top.sv */
`timescale 1ns / 1ps
// Modbus slave register engine. Items enter on the s_axis side, are decoded
// into commands and wait in a two-deep command queue; the executor keeps a
// 64-entry table of 16-bit addresses and values in on-chip memory and sends
// results on the m_axis side through an output register. Every lookup walks
// the table one entry at a time over its single read port, reading an entry
// and then comparing its address until it matches or the table ends. An add
// or an immediate status needs no lookup; a local access or single write
// takes one lookup; a read request of n items sends two header bytes, then
// does n lookups (and sends a low byte as well for each register).
module modbus_slave_register_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // region, offset, local_value, function_code, first_field, second_field
  input  logic [79:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // reply_byte, read_value
  output logic [23:0] m_axis_tdata_o,
  // status
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import mse_pkg::*;
  `include "modbus_slave_register_engine_top_macros.svh"

  cmd_t cmd_in, cmd_out;
  res_t res;
  logic full, empty, pop, push;

  assign s_axis_tready_o = !full;
  assign push            = s_axis_tvalid_i && !full;

  mse_front u_front (
    .opcode_i        (s_axis_tuser_i),
    .region_i        (s_axis_tdata_i[1:0]),
    .offset_i        (s_axis_tdata_i[17:2]),
    .local_value_i   (s_axis_tdata_i[33:18]),
    .function_code_i (s_axis_tdata_i[41:34]),
    .first_field_i   (s_axis_tdata_i[57:42]),
    .second_field_i  (s_axis_tdata_i[73:58]),
    .cmd_o           (cmd_in)
  );

  mse_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  mse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {res.read_value, res.reply_byte};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

  `MSE_ASSERT_NOW(a_byte_only_in_frame, m_axis_tvalid_o && res.status != ST_BYTE, res.reply_byte == 8'd0)
  `MSE_ASSERT_NOW(a_value_only_on_done, m_axis_tvalid_o && res.status != ST_DONE, res.read_value == 16'd0)
  `MSE_ASSERT_NOW(a_status_is_last, m_axis_tvalid_o && res.status != ST_BYTE, res.last)

endmodule
